[src/fst_pkg.sv]
package fst_pkg;

  localparam int LEN_BITS  = 32;
  localparam int IDX_BITS  = 16;
  localparam int NAME_BITS = 8;
  localparam int CHNK_BITS = 16;
  localparam int CFG_BITS  = 16;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam logic [IDX_BITS-1:0] IDX_MAX = {IDX_BITS{1'b1}};

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  localparam logic [NAME_BITS-1:0] NAME_LEN_RST = 8'd255;
  localparam logic [CHNK_BITS-1:0] CHUNK_RST    = 16'd65535;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOI  = 1'b1
  } in_kind_t;

  typedef enum logic {
    REG_MAX_NAME_LEN = 1'b0,
    REG_CHUNK_SIZE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_LINE    = 3'd0,
    PH_COMMENT = 3'd1,
    PH_PRE     = 3'd2,
    PH_NAME    = 3'd3,
    PH_REST    = 3'd4,
    PH_SEQ     = 3'd5,
    PH_ERR     = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    RK_NAME     = 3'd0,
    RK_NAME_END = 3'd1,
    RK_BASE     = 3'd2,
    RK_REC_END  = 3'd3,
    RK_ERROR    = 3'd4
  } res_kind_t;

  typedef enum logic [1:0] {
    ERR_EMPTY_REC = 2'd0,
    ERR_NAME_LONG = 2'd1,
    ERR_NO_NAME   = 2'd2,
    ERR_NO_HEADER = 2'd3
  } err_code_t;

endpackage

[src/fst_if.sv]
interface fst_in_if;
  logic             valid;
  logic             ready;
  fst_pkg::in_kind_t kind;
  logic [7:0]       data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface fst_out_if;
  logic                          valid;
  logic                          ready;
  fst_pkg::res_kind_t            result_kind;
  logic [7:0]                    out_byte;
  logic [fst_pkg::IDX_BITS-1:0]  record_index;
  logic [fst_pkg::LEN_BITS-1:0]  record_length;
  logic                          chunk_end;
  fst_pkg::err_code_t            error_code;

  modport source (output valid, result_kind, out_byte, record_index, record_length,
                  chunk_end, error_code, input ready);
  modport sink   (input valid, result_kind, out_byte, record_index, record_length,
                  chunk_end, error_code, output ready);
endinterface

interface fst_cfg_if;
  logic                          valid;
  logic                          ready;
  fst_pkg::cfg_reg_t             reg_index;
  logic [fst_pkg::CFG_BITS-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[src/fasta_stream_tokenizer_core.sv]
// Channel   Dir  Payload                                                  Handshake
// in_ch     in   kind, data_byte                                          valid/ready
// out_ch    out  result_kind, out_byte, record_index, record_length,      valid/ready
//                chunk_end, error_code
// cfg_ch    in   reg_index, wdata                                         valid/ready (ready=1)
//
// One byte or end-of-input transfer per cycle while out_ch is not stalled; each
// transfer gives at most one result, via input stage register, then parse logic
// into the result register. rst_n is synchronous, active low: parse state goes to
// line start, counters clear, registers take their reset values. A stalled result
// holds the result register; the input stage keeps taking a transfer whenever the
// parse step can retire, so stalls cost nothing while out_ch.ready is high.
module fasta_stream_tokenizer_core (
  input  logic clk,
  input  logic rst_n,
  fst_in_if.sink    in_ch,
  fst_out_if.source out_ch,
  fst_cfg_if.sink   cfg_ch
);
  import fst_pkg::*;

  // configuration
  logic [NAME_BITS-1:0] max_name_r;
  logic [CHNK_BITS-1:0] chunk_size_r;

  // input stage
  logic       stg_valid_r;
  in_kind_t   stg_kind_r;
  logic [7:0] stg_byte_r;

  // parse state
  phase_t               phase_r, phase_nxt;
  logic                 rec_open_r, rec_open_nxt;
  logic [LEN_BITS-1:0]  base_cnt_r, base_cnt_nxt;
  logic [NAME_BITS-1:0] name_cnt_r, name_cnt_nxt;
  logic [CHNK_BITS-1:0] chunk_cnt_r, chunk_cnt_nxt;
  logic [IDX_BITS-1:0]  rec_cnt_r, rec_cnt_nxt;

  // result register
  logic                 out_valid_r;
  res_kind_t            res_kind_r;
  logic [7:0]           res_byte_r;
  logic [IDX_BITS-1:0]  res_index_r;
  logic [LEN_BITS-1:0]  res_len_r;
  logic                 res_cend_r;
  err_code_t            res_err_r;

  // parse step results
  logic       res_emit;
  res_kind_t  res_kind;
  logic [7:0] res_byte;
  logic       res_cend;
  err_code_t  res_err;

  logic       out_free, stg_fire, is_eoi, is_blank, is_nl, rec_empty, hdr_start;
  logic [7:0] up_byte;
  logic [CHNK_BITS:0] chunk_inc;

  assign out_free = !out_valid_r || out_ch.ready;
  assign stg_fire = stg_valid_r && out_free;
  assign in_ch.ready  = !stg_valid_r || stg_fire;
  assign cfg_ch.ready = 1'b1;

  assign is_eoi    = (stg_kind_r == KIND_EOI);
  assign is_blank  = (stg_byte_r == CH_SPACE) || (stg_byte_r == CH_TAB);
  assign is_nl     = (stg_byte_r == CH_NL);
  assign rec_empty = (base_cnt_r == '0);
  assign up_byte   = ((stg_byte_r >= CH_LO_A) && (stg_byte_r <= CH_LO_Z)) ?
                     (stg_byte_r - CH_LO_A + CH_UP_A) : stg_byte_r;
  assign chunk_inc = {1'b0, chunk_cnt_r} + {{CHNK_BITS{1'b0}}, 1'b1};
  // a '>' at line start opens a new header unless the open record is empty
  assign hdr_start = !is_eoi && (phase_r == PH_LINE) && (stg_byte_r == CH_GT) &&
                     !(rec_open_r && rec_empty);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r   <= NAME_LEN_RST;
      chunk_size_r <= CHUNK_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_MAX_NAME_LEN: max_name_r   <= cfg_ch.wdata[NAME_BITS-1:0];
        REG_CHUNK_SIZE:   chunk_size_r <= cfg_ch.wdata[CHNK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_kind_r <= in_ch.kind;
      stg_byte_r <= in_ch.data_byte;
    end
  end

  // next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_eoi) begin
      phase_nxt = PH_LINE;
    end else begin
      unique case (phase_r)
        PH_LINE: begin
          priority if (is_blank || is_nl)     phase_nxt = PH_LINE;
          else if (stg_byte_r == CH_SEMI)     phase_nxt = PH_COMMENT;
          else if (stg_byte_r == CH_GT)       phase_nxt = hdr_start ? PH_PRE : PH_ERR;
          else if (!rec_open_r)               phase_nxt = PH_ERR;
          else                                phase_nxt = PH_SEQ;
        end
        PH_COMMENT, PH_REST: begin
          if (is_nl) phase_nxt = PH_LINE;
        end
        PH_PRE: begin
          priority if (is_blank) phase_nxt = PH_PRE;
          else if (is_nl)        phase_nxt = PH_ERR;
          else                   phase_nxt = PH_NAME;
        end
        PH_NAME: begin
          priority if (is_nl)                 phase_nxt = PH_LINE;
          else if (is_blank)                  phase_nxt = PH_REST;
          else if (name_cnt_r >= max_name_r)  phase_nxt = PH_ERR;
          else                                phase_nxt = PH_NAME;
        end
        PH_SEQ: begin
          if (is_nl) phase_nxt = PH_LINE;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // result of the parse step
  always_comb begin
    res_emit = 1'b0;
    res_kind = RK_NAME;
    res_byte = '0;
    res_cend = 1'b0;
    res_err  = ERR_EMPTY_REC;
    if (is_eoi) begin
      priority if (phase_r == PH_ERR) begin
        res_emit = 1'b0;
      end else if ((phase_r == PH_PRE) || (phase_r == PH_NAME) || (phase_r == PH_REST) ||
                   (rec_open_r && rec_empty)) begin
        res_emit = 1'b1;
        res_kind = RK_ERROR;
      end else if (rec_open_r) begin
        res_emit = 1'b1;
        res_kind = RK_REC_END;
      end else begin
        res_emit = 1'b0;
      end
    end else begin
      unique case (phase_r)
        PH_LINE: begin
          priority if (is_blank || is_nl || (stg_byte_r == CH_SEMI)) begin
            res_emit = 1'b0;
          end else if (stg_byte_r == CH_GT) begin
            res_emit = rec_open_r;
            res_kind = hdr_start ? RK_REC_END : RK_ERROR;
          end else if (!rec_open_r) begin
            res_emit = 1'b1;
            res_kind = RK_ERROR;
            res_err  = ERR_NO_HEADER;
          end else begin
            res_emit = 1'b1;
            res_kind = RK_BASE;
            res_byte = up_byte;
            res_cend = (chunk_inc >= {1'b0, chunk_size_r});
          end
        end
        PH_PRE: begin
          priority if (is_blank) begin
            res_emit = 1'b0;
          end else if (is_nl) begin
            res_emit = 1'b1;
            res_kind = RK_ERROR;
            res_err  = ERR_NO_NAME;
          end else begin
            res_emit = 1'b1;
            res_kind = RK_NAME;
            res_byte = stg_byte_r;
          end
        end
        PH_NAME: begin
          priority if (is_nl || is_blank) begin
            res_emit = 1'b1;
            res_kind = RK_NAME_END;
          end else if (name_cnt_r >= max_name_r) begin
            res_emit = 1'b1;
            res_kind = RK_ERROR;
            res_err  = ERR_NAME_LONG;
          end else begin
            res_emit = 1'b1;
            res_kind = RK_NAME;
            res_byte = stg_byte_r;
          end
        end
        PH_SEQ: begin
          if (!is_nl) begin
            res_emit = 1'b1;
            res_kind = RK_BASE;
            res_byte = up_byte;
            res_cend = (chunk_inc >= {1'b0, chunk_size_r});
          end
        end
        default: res_emit = 1'b0;
      endcase
    end
  end

  // counters and record flag
  always_comb begin
    rec_open_nxt  = rec_open_r;
    base_cnt_nxt  = base_cnt_r;
    name_cnt_nxt  = name_cnt_r;
    chunk_cnt_nxt = chunk_cnt_r;
    rec_cnt_nxt   = rec_cnt_r;
    if (res_emit && (res_kind == RK_REC_END) && (rec_cnt_r != IDX_MAX)) begin
      rec_cnt_nxt = rec_cnt_r + 1'b1;
    end
    if (is_eoi) begin
      rec_open_nxt  = 1'b0;
      base_cnt_nxt  = '0;
      name_cnt_nxt  = '0;
      chunk_cnt_nxt = '0;
    end else if (hdr_start) begin
      rec_open_nxt  = 1'b1;
      base_cnt_nxt  = '0;
      name_cnt_nxt  = '0;
      chunk_cnt_nxt = '0;
    end else if (res_emit && (res_kind == RK_BASE)) begin
      if (base_cnt_r != LEN_MAX) base_cnt_nxt = base_cnt_r + 1'b1;
      chunk_cnt_nxt = res_cend ? '0 : chunk_inc[CHNK_BITS-1:0];
    end else if (res_emit && (res_kind == RK_NAME)) begin
      name_cnt_nxt = (phase_r == PH_PRE) ? NAME_BITS'(1) : (name_cnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LINE;
      rec_open_r  <= 1'b0;
      base_cnt_r  <= '0;
      name_cnt_r  <= '0;
      chunk_cnt_r <= '0;
      rec_cnt_r   <= '0;
    end else if (stg_fire) begin
      phase_r     <= phase_nxt;
      rec_open_r  <= rec_open_nxt;
      base_cnt_r  <= base_cnt_nxt;
      name_cnt_r  <= name_cnt_nxt;
      chunk_cnt_r <= chunk_cnt_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
    end
  end

  // result register: load on a step with a result, drop once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_fire && res_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_fire && res_emit) begin
      res_kind_r  <= res_kind;
      res_byte_r  <= res_byte;
      res_index_r <= rec_cnt_r;
      res_len_r   <= (res_kind == RK_REC_END) ? base_cnt_r : '0;
      res_cend_r  <= res_cend;
      res_err_r   <= res_err;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = res_kind_r;
  assign out_ch.out_byte      = res_byte_r;
  assign out_ch.record_index  = res_index_r;
  assign out_ch.record_length = res_len_r;
  assign out_ch.chunk_end     = res_cend_r;
  assign out_ch.error_code    = res_err_r;

  a_closed_no_bases: assert property (@(posedge clk) disable iff (!rst_n)
    !rec_open_r |-> (base_cnt_r == '0))
    else $error("bases counted with no record open");

  a_header_open: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_PRE) || (phase_r == PH_NAME) || (phase_r == PH_REST)) |-> rec_open_r)
    else $error("header phase without an open record");

  a_name_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NAME) |-> (name_cnt_r != '0))
    else $error("in name with zero name count");

  a_rec_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_kind_r == RK_REC_END)) |-> (res_len_r != '0))
    else $error("record end with zero length");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import fst_pkg::*;

  typedef struct {
    res_kind_t              rkind;
    logic [7:0]             text;
    logic [IDX_BITS-1:0]    rec_idx;
    logic [LEN_BITS-1:0]    rec_len;
    logic                   chunk_last;
    err_code_t              err;
  } token_t;

  // Tracks the parse state of the stream and holds the tokens it should produce.
  class token_tracker;
    token_t                 pending_tokens[$];
    int                     mismatches;
    int                     live_items;
    logic [7:0]             max_name;
    logic [CHNK_BITS-1:0]   chunk_size;
    phase_t                 parse_ph;
    bit                     rec_open;
    logic [LEN_BITS-1:0]    base_cnt;
    logic [NAME_BITS-1:0]   name_cnt;
    int unsigned            chunk_cnt;
    logic [IDX_BITS-1:0]    rec_cnt;

    function new();
      mismatches = 0;
      live_items = 0;
      max_name   = NAME_LEN_RST;
      chunk_size = CHUNK_RST;
      parse_ph   = PH_LINE;
      rec_open   = 1'b0;
      base_cnt   = '0;
      name_cnt   = '0;
      chunk_cnt  = 0;
      rec_cnt    = '0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_BITS-1:0] v);
      if (r == REG_MAX_NAME_LEN) max_name = v[7:0];
      else chunk_size = v[CHNK_BITS-1:0];
    endfunction

    // error_code reads as zero outside error tokens
    function void push_token(res_kind_t k, logic [7:0] t, logic [LEN_BITS-1:0] l,
                             logic c, err_code_t e);
      token_t r;
      r.rkind      = k;
      r.text       = t;
      r.rec_idx    = rec_cnt;
      r.rec_len    = l;
      r.chunk_last = c;
      r.err        = e;
      pending_tokens.push_back(r);
    endfunction

    function void flag(err_code_t e);
      parse_ph = PH_ERR;
      push_token(RK_ERROR, 8'h00, '0, 1'b0, e);
    endfunction

    function void close_record();
      push_token(RK_REC_END, 8'h00, base_cnt, 1'b0, ERR_EMPTY_REC);
      if (rec_cnt != IDX_MAX) rec_cnt++;
      rec_open = 1'b0;
    endfunction

    function void take_base(logic [7:0] b);
      logic last;
      if (b >= CH_LO_A && b <= CH_LO_Z) b = b - CH_LO_A + CH_UP_A;
      if (base_cnt != LEN_MAX) base_cnt++;
      chunk_cnt++;
      last = (chunk_cnt >= chunk_size);
      if (last) chunk_cnt = 0;
      push_token(RK_BASE, b, '0, last, ERR_EMPTY_REC);
    endfunction

    function void note_transfer(in_kind_t k, logic [7:0] b);
      bit blank;
      blank = (b == CH_SPACE) || (b == CH_TAB);
      live_items++;
      if (k == KIND_EOI) begin
        if (parse_ph == PH_PRE || parse_ph == PH_NAME || parse_ph == PH_REST) begin
          flag(ERR_EMPTY_REC);
        end else if (parse_ph != PH_ERR && rec_open) begin
          if (base_cnt == 0) flag(ERR_EMPTY_REC);
          else close_record();
        end
        parse_ph  = PH_LINE;
        rec_open  = 1'b0;
        base_cnt  = '0;
        name_cnt  = '0;
        chunk_cnt = 0;
        return;
      end
      case (parse_ph)
        PH_LINE: begin
          if (b == CH_SEMI) begin
            parse_ph = PH_COMMENT;
          end else if (b == CH_GT) begin
            if (rec_open && base_cnt == 0) begin
              flag(ERR_EMPTY_REC);
            end else begin
              if (rec_open) close_record();
              rec_open  = 1'b1;
              base_cnt  = '0;
              name_cnt  = '0;
              chunk_cnt = 0;
              parse_ph  = PH_PRE;
            end
          end else if (!blank && b != CH_NL) begin
            if (!rec_open) begin
              flag(ERR_NO_HEADER);
            end else begin
              parse_ph = PH_SEQ;
              take_base(b);
            end
          end
        end
        PH_COMMENT, PH_REST: begin
          if (b == CH_NL) parse_ph = PH_LINE;
        end
        PH_PRE: begin
          if (b == CH_NL) begin
            flag(ERR_NO_NAME);
          end else if (!blank) begin
            name_cnt = 1;
            parse_ph = PH_NAME;
            push_token(RK_NAME, b, '0, 1'b0, ERR_EMPTY_REC);
          end
        end
        PH_NAME: begin
          if (b == CH_NL || blank) begin
            parse_ph = (b == CH_NL) ? PH_LINE : PH_REST;
            push_token(RK_NAME_END, 8'h00, '0, 1'b0, ERR_EMPTY_REC);
          end else if (name_cnt >= max_name) begin
            flag(ERR_NAME_LONG);
          end else begin
            name_cnt = name_cnt + 1'b1;
            push_token(RK_NAME, b, '0, 1'b0, ERR_EMPTY_REC);
          end
        end
        PH_SEQ: begin
          if (b == CH_NL) parse_ph = PH_LINE;
          else take_base(b);
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task check_token(token_t got);
      token_t want;
      if (pending_tokens.size() == 0) begin
        report("unexpected result_kind", got.rkind, 32'h0);
        return;
      end
      want = pending_tokens.pop_front();
      if (got.rkind !== want.rkind) report("result_kind", got.rkind, want.rkind);
      if (got.text !== want.text) report("out_byte", got.text, want.text);
      if (got.rec_idx !== want.rec_idx) report("record_index", got.rec_idx, want.rec_idx);
      if (got.rec_len !== want.rec_len) report("record_length", got.rec_len, want.rec_len);
      if (got.chunk_last !== want.chunk_last)
        report("chunk_end", got.chunk_last, want.chunk_last);
      if (got.err !== want.err) report("error_code", got.err, want.err);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  bit   hold_req;

  token_tracker sb = new();

  fst_in_if  in_ch();
  fst_out_if out_ch();
  fst_cfg_if cfg_ch();

  fasta_stream_tokenizer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    token_t got;
    if (rst_n === 1'b1) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.reg_index, cfg_ch.wdata);
      if (in_ch.valid && in_ch.ready) sb.note_transfer(in_ch.kind, in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.rkind      = out_ch.result_kind;
        got.text       = out_ch.out_byte;
        got.rec_idx    = out_ch.record_index;
        got.rec_len    = out_ch.record_length;
        got.chunk_last = out_ch.chunk_end;
        got.err        = out_ch.error_code;
        sb.check_token(got);
      end
    end
  end

  task automatic send_item(in_kind_t k, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_DATA, s[i]);
  endtask

  task automatic send_eoi();
    send_item(KIND_EOI, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] first;
    first = $urandom_range(1) ? CH_LO_A : CH_UP_A;
    return first + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // any byte but newline; no blanks either when no_blank is set
  function automatic logic [7:0] pick_plain(bit no_blank);
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_NL || (no_blank && (b == CH_SPACE || b == CH_TAB)));
    return b;
  endfunction

  task automatic send_record();
    int name_max;
    int n;
    int lines;
    name_max = (sb.max_name == 0) ? 1 : sb.max_name;
    repeat ($urandom_range(2)) send_item(KIND_DATA, pick_blank());
    send_item(KIND_DATA, CH_GT);
    repeat ($urandom_range(1)) send_item(KIND_DATA, pick_blank());
    n = $urandom_range(1, (name_max < 8) ? name_max : 8);
    // keep full-length names rare where the limit is large
    if (name_max <= 16 || $urandom_range(39) == 0) begin
      case ($urandom_range(9))
        0: n = name_max + 1;
        1: n = name_max;
        default: begin
        end
      endcase
    end
    repeat (n) send_item(KIND_DATA, pick_plain(1'b1));
    if ($urandom_range(19) == 0) begin
      send_eoi();
      return;
    end
    if ($urandom_range(1)) begin
      send_item(KIND_DATA, pick_blank());
      repeat ($urandom_range(4)) send_item(KIND_DATA, pick_plain(1'b0));
    end
    send_item(KIND_DATA, CH_NL);
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1)) send_item(KIND_DATA, pick_blank());
      send_item(KIND_DATA, CH_SEMI);
      repeat ($urandom_range(4)) send_item(KIND_DATA, pick_plain(1'b0));
      send_item(KIND_DATA, CH_NL);
    end
    lines = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
    repeat (lines) begin
      if ($urandom_range(7) == 0) send_item(KIND_DATA, CH_NL);
      if ($urandom_range(3) == 0) send_item(KIND_DATA, pick_blank());
      send_item(KIND_DATA, pick_letter());
      repeat ($urandom_range(15))
        send_item(KIND_DATA, ($urandom_range(4) == 0) ? pick_plain(1'b0) : pick_letter());
      send_item(KIND_DATA, CH_NL);
    end
  endtask

  // Wait for every pending token, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] name_max, logic [CHNK_BITS-1:0] chunk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= REG_MAX_NAME_LEN;
    cfg_ch.wdata     <= {8'($urandom), name_max};
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.reg_index <= REG_CHUNK_SIZE;
    cfg_ch.wdata     <= chunk;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int goal;
    int r;
    rst_n            <= 1'b0;
    hold_req         <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_DATA;
    in_ch.data_byte  <= 8'h00;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_MAX_NAME_LEN;
    cfg_ch.wdata     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bases with no header, then end of input with nothing open
    send_item(KIND_DATA, CH_UP_A);
    send_eoi();
    send_eoi();
    send_text(" \t;c\n");
    // header: blanks before the name, extreme name bytes, rest of line dropped
    send_item(KIND_DATA, CH_GT);
    send_item(KIND_DATA, CH_TAB);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_text(" x\n");
    send_text("az{");
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, CH_NL);
    // record end, then newline before the name
    send_text(">\n");
    send_eoi();
    // previous record empty
    send_text(">p\n>");
    send_eoi();
    // end inside a header
    send_text(">q");
    send_eoi();
    drain();

    // a zero name limit acts as one; a zero chunk size ends every chunk
    apply_config(8'd0, 16'd0);
    send_text(">ab");
    send_eoi();
    send_text(">x\nAbc\n");
    send_eoi();
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          apply_config(8'd1, 16'd1);
          src_idle_pct = 0;  sink_stall_pct = 0;
        end
        1: begin
          apply_config(8'd255, 16'd65535);
          src_idle_pct = 64; sink_stall_pct = 0;
        end
        2: begin
          apply_config(8'd5, 16'd4);
          src_idle_pct = 0;  sink_stall_pct = 64;
        end
        3: begin
          apply_config(8'($urandom_range(1, 255)), 16'($urandom_range(1, 16)));
          src_idle_pct = 21; sink_stall_pct = 21;
        end
        4: begin
          apply_config(8'd255, 16'd7);
          src_idle_pct = 0;  sink_stall_pct = 0;
          // hold the receiver off while the sender keeps offering
          hold_req <= 1'b1;
        end
        default: begin
          apply_config(8'd2, 16'd2);
          src_idle_pct = 21; sink_stall_pct = 21;
        end
      endcase
      goal = sb.live_items + 90;
      while (sb.live_items < goal) begin
        r = $urandom_range(99);
        if (r < 8) begin
          repeat ($urandom_range(1, 6))
            send_item(($urandom_range(4) == 0) ? KIND_EOI : KIND_DATA, 8'($urandom));
        end else if (r < 30) begin
          send_eoi();
        end else begin
          send_record();
        end
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
